[rtl/core/bsd_pkg.sv]
// shared constants, types and the square root step for the box distance block
`default_nettype none
package bsd_pkg;

    localparam int COORD_BITS = 10;
    localparam int FRAC_BITS  = 8;
    localparam int REG_W      = 20;
    localparam int OUT_W      = 22;
    localparam int ADDR_W     = 5;
    localparam int DATA_W     = 32;

    // unsigned width of a cell centre
    localparam int P_W    = COORD_BITS + FRAC_BITS;
    // signed width of a centre to face difference
    localparam int D_W    = ((REG_W > P_W) ? REG_W : P_W) + 2;
    localparam int SQ_W   = 2 * D_W;
    localparam int SUM_W  = SQ_W + 2;
    localparam int ROOT_W = SUM_W / 2;
    localparam int STEPS  = 3;
    localparam int NSTG   = (ROOT_W + STEPS - 1) / STEPS;

    typedef struct packed {
        logic                  lin;
        logic signed [D_W-1:0] slab;
    } side_t;

    typedef struct packed {
        logic [SUM_W-1:0] v;
        logic [SUM_W-1:0] r;
    } rt_t;

    // one bit of the digit by digit square root
    function automatic rt_t sqrt_step(input rt_t s, input int k);
        logic [SUM_W-1:0] b;
        logic [SUM_W-1:0] t;
        rt_t              o;
        b = '0;
        b[SUM_W-2-2*k] = 1'b1;
        t = s.r + b;
        o = s;
        if (s.v >= t)
        begin
            o.v = s.v - t;
            o.r = (s.r >> 1) + b;
        end
        else
        begin
            o.r = s.r >> 1;
        end
        return o;
    endfunction

endpackage
`default_nettype wire

[rtl/core/bsd_isqrt.sv]
// pipelined integer square root, up to three result bits per stage
`default_nettype none
module bsd_isqrt
    import bsd_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              en,
    input  wire logic              in_valid,
    input  wire logic [SUM_W-1:0]  in_val,
    input  wire side_t             in_side,
    output logic                   out_valid,
    output logic [ROOT_W-1:0]      out_root,
    output side_t                  out_side
);

    logic  valid_reg [NSTG];
    rt_t   st_reg    [NSTG];
    side_t side_reg  [NSTG];
    rt_t   st_next   [NSTG];
    logic  valid_in  [NSTG];
    rt_t   st_in     [NSTG];
    side_t side_in   [NSTG];

    for (genvar g = 0; g < NSTG; g++)
    begin : g_stage
        if (g == 0)
        begin : g_head
            assign valid_in[g] = in_valid;
            assign st_in[g]    = {in_val, SUM_W'(0)};
            assign side_in[g]  = in_side;
        end
        else
        begin : g_tail
            assign valid_in[g] = valid_reg[g-1];
            assign st_in[g]    = st_reg[g-1];
            assign side_in[g]  = side_reg[g-1];
        end

        always_comb
        begin
            rt_t s;
            s = st_in[g];
            for (int j = 0; j < STEPS; j++)
            begin
                if (g * STEPS + j < ROOT_W)
                begin
                    s = sqrt_step(s, g * STEPS + j);
                end
            end
            st_next[g] = s;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[g] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[g] <= valid_in[g];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                st_reg[g]   <= st_next[g];
                side_reg[g] <= side_in[g];
            end
        end
    end

    assign out_valid = valid_reg[NSTG-1];
    assign out_root  = st_reg[NSTG-1].r[ROOT_W-1:0];
    assign out_side  = side_reg[NSTG-1];

endmodule
`default_nettype wire

[rtl/core/box_signed_distance.sv]
// top level: signed distance from a grid cell centre to a configured box
// One cell word enters per clock while in_stall is low; its distance passes
// four stages of differences, case selection, squaring and summing, then the
// pipelined square root at up to three result bits per stage, then the output
// register. A stall on the output holds the whole pipeline; in_stall is raised
// only while a finished word waits and out_stall is high. Box corners must
// be written over the APB port only while the block is idle (not enforced).
`default_nettype none
module box_signed_distance
    import bsd_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [ADDR_W-1:0]     paddr,
    input  wire logic [DATA_W-1:0]     pwdata,
    output logic [DATA_W-1:0]          prdata,
    output logic                       pready,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic [COORD_BITS-1:0] cell_x,
    input  wire logic [COORD_BITS-1:0] cell_y,
    input  wire logic [COORD_BITS-1:0] cell_z,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic signed [OUT_W-1:0]    distance
);

    localparam logic [2:0] REG_MIN_X = 3'd0;
    localparam logic [2:0] REG_MIN_Y = 3'd1;
    localparam logic [2:0] REG_MIN_Z = 3'd2;
    localparam logic [2:0] REG_MAX_X = 3'd3;
    localparam logic [2:0] REG_MAX_Y = 3'd4;
    localparam logic [2:0] REG_MAX_Z = 3'd5;

    localparam logic [D_W-1:0] HALF = D_W'(1) << (FRAC_BITS - 1);
    localparam int W_W = (D_W > ROOT_W + 1) ? D_W : ROOT_W + 1;
    localparam logic signed [W_W-1:0] SAT_HI = W_W'((64'sd1 <<< (OUT_W - 1)) - 1);
    localparam logic signed [W_W-1:0] SAT_LO = -(W_W'(64'sd1 <<< (OUT_W - 1)));

    logic signed [REG_W-1:0] bmin_reg [3];
    logic signed [REG_W-1:0] bmax_reg [3];

    logic en;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int a = 0; a < 3; a++)
            begin
                bmin_reg[a] <= '0;
                bmax_reg[a] <= '0;
            end
        end
        else if (psel && penable && pwrite)
        begin
            case (paddr[4:2])
                REG_MIN_X: bmin_reg[0] <= pwdata[REG_W-1:0];
                REG_MIN_Y: bmin_reg[1] <= pwdata[REG_W-1:0];
                REG_MIN_Z: bmin_reg[2] <= pwdata[REG_W-1:0];
                REG_MAX_X: bmax_reg[0] <= pwdata[REG_W-1:0];
                REG_MAX_Y: bmax_reg[1] <= pwdata[REG_W-1:0];
                REG_MAX_Z: bmax_reg[2] <= pwdata[REG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[4:2])
            REG_MIN_X: prdata = DATA_W'(bmin_reg[0]);
            REG_MIN_Y: prdata = DATA_W'(bmin_reg[1]);
            REG_MIN_Z: prdata = DATA_W'(bmin_reg[2]);
            REG_MAX_X: prdata = DATA_W'(bmax_reg[0]);
            REG_MAX_Y: prdata = DATA_W'(bmax_reg[1]);
            REG_MAX_Z: prdata = DATA_W'(bmax_reg[2]);
            default:   prdata = '0;
        endcase
    end

    assign pready = 1'b1;

    assign en       = !(out_valid && out_stall);
    assign in_stall = !en;

    // stage 1: differences to both faces on each axis
    logic [COORD_BITS-1:0]   cell_idx [3];
    logic signed [D_W-1:0]   lo_next [3];
    logic signed [D_W-1:0]   hi_next [3];
    logic signed [D_W-1:0]   lo_reg  [3];
    logic signed [D_W-1:0]   hi_reg  [3];
    logic                    v1_reg;

    assign cell_idx[0] = cell_x;
    assign cell_idx[1] = cell_y;
    assign cell_idx[2] = cell_z;

    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            logic signed [D_W-1:0] p;
            p = signed'(D_W'({cell_idx[a], FRAC_BITS'(0)}) + HALF);
            lo_next[a] = D_W'(bmin_reg[a]) - p;
            hi_next[a] = p - D_W'(bmax_reg[a]);
        end
    end

    // stage 2: region decision, linear result and the magnitudes to square
    logic                  wi [3];
    logic                  st [3];
    logic signed [D_W-1:0] sl [3];
    logic [D_W-1:0]        mg [3];
    logic [2:0]            use_mask;
    side_t                 side_next;
    logic [D_W-1:0]        mag_reg [3];
    side_t                 side2_reg;
    logic                  v2_reg;

    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            logic [D_W-1:0] al;
            logic [D_W-1:0] ah;
            wi[a] = (lo_reg[a] <= 0) && (hi_reg[a] <= 0);
            st[a] = (lo_reg[a] < 0) && (hi_reg[a] < 0);
            sl[a] = (hi_reg[a] > lo_reg[a]) ? hi_reg[a] : lo_reg[a];
            al = lo_reg[a][D_W-1] ? D_W'(-lo_reg[a]) : D_W'(lo_reg[a]);
            ah = hi_reg[a][D_W-1] ? D_W'(-hi_reg[a]) : D_W'(hi_reg[a]);
            mg[a] = (al < ah) ? al : ah;
        end
        side_next.lin  = 1'b1;
        side_next.slab = sl[0];
        use_mask       = 3'b000;
        if (wi[0] && wi[1] && wi[2])
        begin
            side_next.slab = (sl[1] > sl[0]) ? sl[1] : sl[0];
            if (sl[2] > side_next.slab)
            begin
                side_next.slab = sl[2];
            end
        end
        else if (wi[1] && wi[2])
        begin
            side_next.slab = sl[0];
        end
        else if (wi[0] && wi[2])
        begin
            side_next.slab = sl[1];
        end
        else if (wi[0] && wi[1])
        begin
            side_next.slab = sl[2];
        end
        else
        begin
            side_next.lin = 1'b0;
            if (st[0])
            begin
                use_mask = 3'b110;
            end
            else if (st[1])
            begin
                use_mask = 3'b101;
            end
            else if (st[2])
            begin
                use_mask = 3'b011;
            end
            else
            begin
                use_mask = 3'b111;
            end
        end
    end

    // stage 3: squares, stage 4: sum
    logic [SQ_W-1:0]  sq_reg [3];
    side_t            side3_reg;
    logic             v3_reg;
    logic [SUM_W-1:0] sum_reg;
    side_t            side4_reg;
    logic             v4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int a = 0; a < 3; a++)
            begin
                lo_reg[a]  <= lo_next[a];
                hi_reg[a]  <= hi_next[a];
                mag_reg[a] <= use_mask[a] ? mg[a] : '0;
                sq_reg[a]  <= SQ_W'(mag_reg[a]) * SQ_W'(mag_reg[a]);
            end
            side2_reg <= side_next;
            side3_reg <= side2_reg;
            sum_reg   <= SUM_W'(sq_reg[0]) + SUM_W'(sq_reg[1]) + SUM_W'(sq_reg[2]);
            side4_reg <= side3_reg;
        end
    end

    logic              rt_valid;
    logic [ROOT_W-1:0] rt_root;
    side_t             rt_side;

    bsd_isqrt u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v4_reg),
        .in_val    (sum_reg),
        .in_side   (side4_reg),
        .out_valid (rt_valid),
        .out_root  (rt_root),
        .out_side  (rt_side)
    );

    // output word with saturation
    logic signed [W_W-1:0] res;
    logic signed [OUT_W-1:0] dist_next;
    logic                    out_valid_reg;
    logic signed [OUT_W-1:0] distance_reg;

    always_comb
    begin
        res = rt_side.lin ? W_W'(rt_side.slab) : signed'(W_W'(rt_root));
        if (res > SAT_HI)
        begin
            dist_next = OUT_W'(SAT_HI);
        end
        else if (res < SAT_LO)
        begin
            dist_next = OUT_W'(SAT_LO);
        end
        else
        begin
            dist_next = OUT_W'(res);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= rt_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            distance_reg <= dist_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign distance  = distance_reg;

endmodule
`default_nettype wire

[tb/bsd_checker.sv]
// checker: watches both channels, predicts each distance and compares in order
`timescale 1ns / 1ps
module bsd_checker
    import bsd_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [ADDR_W-1:0]     paddr,
    input  wire logic [DATA_W-1:0]     pwdata,
    input  wire logic                  pready,
    input  wire logic                  in_valid,
    input  wire logic                  in_stall,
    input  wire logic [COORD_BITS-1:0] cell_x,
    input  wire logic [COORD_BITS-1:0] cell_y,
    input  wire logic [COORD_BITS-1:0] cell_z,
    input  wire logic                  out_valid,
    input  wire logic                  out_stall,
    input  wire logic signed [OUT_W-1:0] distance,
    output int                         fail_count,
    output int                         pending
);

    localparam int REG_MIN_X = 0;
    localparam int REG_MAX_X = 3;

    longint corner_lo [3];
    longint corner_hi [3];
    logic signed [OUT_W-1:0] expected_dist [$];

    function automatic longint iroot(longint unsigned v);
        longint unsigned res;
        longint unsigned bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (v >= res + bitv)
            begin
                v = v - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return longint'(res);
    endfunction

    function automatic longint unsigned sqr(longint d);
        longint unsigned m;
        m = (d < 0) ? -d : d;
        return m * m;
    endfunction

    // squared distance to the nearer of the two faces on one axis
    function automatic longint unsigned near_sq(longint p[3], int a);
        longint unsigned s0;
        longint unsigned s1;
        s0 = sqr(corner_lo[a] - p[a]);
        s1 = sqr(corner_hi[a] - p[a]);
        return (s0 < s1) ? s0 : s1;
    endfunction

    function automatic longint slab_of(longint p[3], int a);
        longint u;
        longint w;
        u = p[a] - corner_hi[a];
        w = corner_lo[a] - p[a];
        return (u > w) ? u : w;
    endfunction

    function automatic logic signed [OUT_W-1:0] box_distance(
        logic [COORD_BITS-1:0] cx, logic [COORD_BITS-1:0] cy, logic [COORD_BITS-1:0] cz);
        longint p [3];
        bit     inr [3];
        longint d;
        longint m;
        p[0] = (longint'(cx) << FRAC_BITS) + (64'sd1 << (FRAC_BITS - 1));
        p[1] = (longint'(cy) << FRAC_BITS) + (64'sd1 << (FRAC_BITS - 1));
        p[2] = (longint'(cz) << FRAC_BITS) + (64'sd1 << (FRAC_BITS - 1));
        for (int a = 0; a < 3; a++)
            inr[a] = (p[a] <= corner_hi[a]) && (p[a] >= corner_lo[a]);
        if (inr[0] && inr[1] && inr[2])
        begin
            d = slab_of(p, 0);
            m = slab_of(p, 1);
            if (m > d) d = m;
            m = slab_of(p, 2);
            if (m > d) d = m;
        end
        else if (inr[1] && inr[2])
            d = slab_of(p, 0);
        else if (inr[0] && inr[2])
            d = slab_of(p, 1);
        else if (inr[0] && inr[1])
            d = slab_of(p, 2);
        else if (p[0] > corner_lo[0] && p[0] < corner_hi[0])
            d = iroot(near_sq(p, 1) + near_sq(p, 2));
        else if (p[1] > corner_lo[1] && p[1] < corner_hi[1])
            d = iroot(near_sq(p, 0) + near_sq(p, 2));
        else if (p[2] > corner_lo[2] && p[2] < corner_hi[2])
            d = iroot(near_sq(p, 0) + near_sq(p, 1));
        else
            d = iroot(near_sq(p, 0) + near_sq(p, 1) + near_sq(p, 2));
        if (d > 2097151) d = 2097151;
        if (d < -2097152) d = -2097152;
        return d[OUT_W-1:0];
    endfunction

    assign pending = expected_dist.size();

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int a = 0; a < 3; a++)
            begin
                corner_lo[a] = 0;
                corner_hi[a] = 0;
            end
            fail_count = 0;
            expected_dist.delete();
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                int idx;
                longint v;
                idx = paddr >> 2;
                v = longint'(signed'(pwdata[REG_W-1:0]));
                if (idx < REG_MAX_X)
                    corner_lo[idx - REG_MIN_X] = v;
                else if (idx < REG_MAX_X + 3)
                    corner_hi[idx - REG_MAX_X] = v;
            end
            if (out_valid && !out_stall)
            begin
                if (expected_dist.size() == 0)
                begin
                    $display("%0t: unexpected distance word %0d", $time, distance);
                    fail_count++;
                end
                else
                begin
                    logic signed [OUT_W-1:0] e;
                    e = expected_dist.pop_front();
                    if (e !== distance)
                    begin
                        $display("%0t: distance expected %0d actual %0d", $time, e, distance);
                        fail_count++;
                    end
                end
            end
            if (in_valid && !in_stall)
                expected_dist = {expected_dist, box_distance(cell_x, cell_y, cell_z)};
        end
    end

endmodule

[tb/tb_top.sv]
// testbench top: drives cells and box corners into the block and reports the verdict
`timescale 1ns / 1ps
module tb_top;
    import bsd_pkg::*;

    localparam int REG_MIN_X = 0;
    localparam int REG_MIN_Y = 1;
    localparam int REG_MIN_Z = 2;
    localparam int REG_MAX_X = 3;
    localparam int REG_MAX_Y = 4;
    localparam int REG_MAX_Z = 5;
    localparam int LATENCY   = 20;
    localparam int WATCHDOG  = 20000;

    logic clk;
    logic rst_n;
    logic psel, penable, pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic pready;
    logic in_valid, in_stall;
    logic [COORD_BITS-1:0] cell_x, cell_y, cell_z;
    logic out_valid, out_stall;
    logic signed [OUT_W-1:0] distance;
    int fail_count;
    int pending;
    int idle_cycles;

    box_signed_distance DUT (.*);

    bsd_checker chk (.*);

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // receiver stalls at random, with stretches of none
    int stall_mode;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stall_mode <= 0;
            out_stall  <= 1'b0;
        end
        else
        begin
            if ($urandom_range(0, 199) == 0)
                stall_mode <= $urandom_range(0, 2);
            if (stall_mode == 0)
                out_stall <= 1'b0;
            else if (stall_mode == 1)
                out_stall <= ($urandom_range(0, 3) == 0);
            else
                out_stall <= ($urandom_range(0, 9) < 6);
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            idle_cycles <= 0;
        else if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    always @(posedge clk)
    begin
        if (idle_cycles >= WATCHDOG)
        begin
            $display("box_signed_distance verification failed");
            $finish;
        end
    end

    task automatic reg_write(int idx, logic signed [REG_W-1:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(4 * idx);
        pwdata  <= DATA_W'(v);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic wait_idle();
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (LATENCY) @(posedge clk);
    endtask

    task automatic set_box(logic signed [REG_W-1:0] x0, logic signed [REG_W-1:0] y0,
                           logic signed [REG_W-1:0] z0, logic signed [REG_W-1:0] x1,
                           logic signed [REG_W-1:0] y1, logic signed [REG_W-1:0] z1);
        wait_idle();
        reg_write(REG_MIN_X, x0);
        reg_write(REG_MIN_Y, y0);
        reg_write(REG_MIN_Z, z0);
        reg_write(REG_MAX_X, x1);
        reg_write(REG_MAX_Y, y1);
        reg_write(REG_MAX_Z, z1);
    endtask

    // one word: gap first, then hold valid until accepted
    task automatic send_cell(logic [COORD_BITS-1:0] x, logic [COORD_BITS-1:0] y,
                             logic [COORD_BITS-1:0] z, bit with_gap);
        int g;
        g = with_gap ? gap_len() : 0;
        if (g > 0)
        begin
            in_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        in_valid <= 1'b1;
        cell_x   <= x;
        cell_y   <= y;
        cell_z   <= z;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    function automatic logic signed [REG_W-1:0] rand_corner();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return -20'sd524288;
        if (r == 1) return 20'sd524287;
        if (r < 5) return REG_W'($urandom());
        return REG_W'($urandom_range(0, 1023 * 256 + 255));
    endfunction

    task automatic rand_box();
        logic signed [REG_W-1:0] lo [3];
        logic signed [REG_W-1:0] hi [3];
        logic signed [REG_W-1:0] t;
        for (int a = 0; a < 3; a++)
        begin
            lo[a] = rand_corner();
            hi[a] = rand_corner();
            // mostly proper boxes, sometimes inverted
            if (lo[a] > hi[a] && $urandom_range(0, 4) != 0)
            begin
                t = lo[a];
                lo[a] = hi[a];
                hi[a] = t;
            end
        end
        set_box(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]);
    endtask

    function automatic logic [COORD_BITS-1:0] rand_coord();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return '0;
        if (r == 1) return '1;
        return COORD_BITS'($urandom());
    endfunction

    bit use_gaps;

    initial
    begin
        rst_n     = 1'b0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        in_valid  = 1'b0;
        cell_x    = '0;
        cell_y    = '0;
        cell_z    = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset box is a point at the origin
        send_cell('0, '0, '0, 1);
        send_cell('1, '1, '1, 1);
        send_cell(10'h2AA, 10'h155, 10'h3FF, 1);
        in_valid <= 1'b0;

        // box 16..32 on each axis: inside, faces, edges, corners
        set_box(20'sd4096, 20'sd4096, 20'sd4096, 20'sd8192, 20'sd8192, 20'sd8192);
        send_cell(10'd20, 10'd20, 10'd20, 0);
        send_cell(10'd16, 10'd31, 10'd24, 0);
        send_cell(10'd40, 10'd20, 10'd20, 0);
        send_cell(10'd20, 10'd2, 10'd20, 0);
        send_cell(10'd20, 10'd20, 10'd60, 0);
        send_cell(10'd20, 10'd40, 10'd40, 0);
        send_cell(10'd40, 10'd20, 10'd40, 0);
        send_cell(10'd40, 10'd40, 10'd20, 0);
        send_cell(10'd0, 10'd0, 10'd0, 0);
        send_cell(10'd1023, 10'd1023, 10'd1023, 0);
        send_cell(10'd0, 10'd1023, 10'd0, 0);
        in_valid <= 1'b0;

        // far negative corners give large positive distances
        set_box(-20'sd524288, -20'sd524288, -20'sd524288,
                -20'sd524288, -20'sd524288, -20'sd524288);
        send_cell('1, '1, '1, 0);
        send_cell('0, '1, '0, 0);
        in_valid <= 1'b0;

        // widest box: deep inside
        set_box(-20'sd524288, -20'sd524288, -20'sd524288,
                20'sd524287, 20'sd524287, 20'sd524287);
        send_cell(10'd512, 10'd512, 10'd512, 0);
        send_cell('0, '1, 10'd3, 0);
        in_valid <= 1'b0;

        // inverted box on every axis
        set_box(20'sd8192, 20'sd8192, 20'sd8192, 20'sd4096, 20'sd4096, 20'sd4096);
        send_cell(10'd20, 10'd20, 10'd20, 0);
        send_cell(10'd5, 10'd50, 10'd20, 0);
        in_valid <= 1'b0;

        for (int phase = 0; phase < 10; phase++)
        begin
            rand_box();
            use_gaps = (phase % 3 != 1);
            for (int i = 0; i < 100; i++)
            begin
                send_cell(rand_coord(), rand_coord(), rand_coord(), use_gaps);
                // sender holds off until the pipeline drains
                if (i == 50 && phase == 4)
                begin
                    in_valid <= 1'b0;
                    @(posedge clk);
                    while (pending != 0)
                        @(posedge clk);
                end
            end
            in_valid <= 1'b0;
        end

        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (LATENCY) @(posedge clk);
        if (fail_count == 0)
            $display("box_signed_distance verification clean");
        else
            $display("box_signed_distance verification failed");
        $finish;
    end

endmodule

[box_signed_distance.f]
rtl/core/bsd_pkg.sv
rtl/core/bsd_isqrt.sv
rtl/core/box_signed_distance.sv
tb/bsd_checker.sv
tb/tb_top.sv
